[hw/rtl/assert_macros.svh]
// Assertion macros used by the property checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/prs_pkg.sv]
`default_nettype none

package prs_pkg;

	localparam int IDX_W  = 9;   // request index width
	localparam int SUM_W  = 18;  // prefix sum width
	localparam int CAND_W = 11;  // candidate width
	localparam int DIV_W  = 6;   // trial divisor width
	localparam int REM_W  = 6;   // remainder width (rem < divisor)
	localparam int BIT_W  = 4;   // dividend bit pointer
	localparam int UPC_W  = 4;   // microcode address
	localparam int COND_W = 4;

	localparam logic [CAND_W-1:0] CAND_START = CAND_W'(2);
	localparam logic [BIT_W-1:0]  BIT_TOP    = BIT_W'(CAND_W - 1);

	// microcode addresses
	localparam logic [UPC_W-1:0] S_DINIT = 4'd0;   // divisor := 2
	localparam logic [UPC_W-1:0] S_SQ    = 4'd1;   // d*d > cand ?
	localparam logic [UPC_W-1:0] S_DVI   = 4'd2;   // remainder setup
	localparam logic [UPC_W-1:0] S_DVS   = 4'd3;   // one remainder bit
	localparam logic [UPC_W-1:0] S_CHK   = 4'd4;   // remainder zero ?
	localparam logic [UPC_W-1:0] S_DINC  = 4'd5;   // next divisor
	localparam logic [UPC_W-1:0] S_PRIME = 4'd6;   // record prime
	localparam logic [UPC_W-1:0] S_NEXT  = 4'd7;   // next candidate
	localparam logic [UPC_W-1:0] S_IDLE  = 4'd8;   // wait for request
	localparam logic [UPC_W-1:0] S_RDHI  = 4'd9;   // read upper prefix
	localparam logic [UPC_W-1:0] S_RDLO  = 4'd10;  // read lower prefix
	localparam logic [UPC_W-1:0] S_RES   = 4'd11;  // subtract, emit

	// jump conditions
	localparam logic [COND_W-1:0] C_NONE     = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
	localparam logic [COND_W-1:0] C_LT2      = 4'd2;
	localparam logic [COND_W-1:0] C_SQ_GT    = 4'd3;
	localparam logic [COND_W-1:0] C_BIT_MORE = 4'd4;
	localparam logic [COND_W-1:0] C_REM_ZERO = 4'd5;
	localparam logic [COND_W-1:0] C_NOT_FULL = 4'd6;
	localparam logic [COND_W-1:0] C_NO_IN    = 4'd7;
	localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd8;

	// table read select
	localparam logic [1:0] RD_NONE = 2'd0;
	localparam logic [1:0] RD_HI   = 2'd1;
	localparam logic [1:0] RD_LO   = 2'd2;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [UPC_W-1:0]  jmp;
		logic [UPC_W-1:0]  nxt;
		logic              d_init;
		logic              d_inc;
		logic              div_init;
		logic              div_step;
		logic              prime_wr;
		logic              cand_inc;
		logic              accept;
		logic [1:0]        rd_sel;
		logic              hi_load;
		logic              result;
	} uop_t;

	typedef struct packed {
		logic lt2;
		logic sq_gt;
		logic bit_more;
		logic rem_zero;
		logic not_full;
		logic in_req;
		logic out_busy;
	} flags_t;

	// control store
	function automatic uop_t ucode(input logic [UPC_W-1:0] upc);
		uop_t u;
		u = '0;
		case (upc)
			S_DINIT: begin
				u.d_init = 1'b1;
				u.cond = C_LT2; u.jmp = S_NEXT; u.nxt = S_SQ;
			end
			S_SQ: begin
				u.cond = C_SQ_GT; u.jmp = S_PRIME; u.nxt = S_DVI;
			end
			S_DVI: begin
				u.div_init = 1'b1;
				u.cond = C_NONE; u.jmp = S_DVS; u.nxt = S_DVS;
			end
			S_DVS: begin
				u.div_step = 1'b1;
				u.cond = C_BIT_MORE; u.jmp = S_DVS; u.nxt = S_CHK;
			end
			S_CHK: begin
				u.cond = C_REM_ZERO; u.jmp = S_NEXT; u.nxt = S_DINC;
			end
			S_DINC: begin
				u.d_inc = 1'b1;
				u.cond = C_ALWAYS; u.jmp = S_SQ; u.nxt = S_SQ;
			end
			S_PRIME: begin
				u.prime_wr = 1'b1;
				u.cond = C_NONE; u.jmp = S_NEXT; u.nxt = S_NEXT;
			end
			S_NEXT: begin
				u.cand_inc = 1'b1;
				u.cond = C_NOT_FULL; u.jmp = S_DINIT; u.nxt = S_IDLE;
			end
			S_IDLE: begin
				u.accept = 1'b1;
				u.cond = C_NO_IN; u.jmp = S_IDLE; u.nxt = S_RDHI;
			end
			S_RDHI: begin
				u.rd_sel = RD_HI;
				u.cond = C_NONE; u.jmp = S_RDLO; u.nxt = S_RDLO;
			end
			S_RDLO: begin
				u.rd_sel = RD_LO;
				u.hi_load = 1'b1;
				u.cond = C_NONE; u.jmp = S_RES; u.nxt = S_RES;
			end
			S_RES: begin
				u.result = 1'b1;
				u.cond = C_OUT_BUSY; u.jmp = S_RES; u.nxt = S_IDLE;
			end
			default: begin
				u.cond = C_NONE; u.jmp = S_IDLE; u.nxt = S_IDLE;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/prs_useq.sv]
`default_nettype none

module prs_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  prs_pkg::flags_t flags,
	output prs_pkg::uop_t   uop
);
	import prs_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic             take;

	assign uop = ucode(upc_q);

	always_comb begin
		case (uop.cond)
			C_NONE:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_LT2:      take = flags.lt2;
			C_SQ_GT:    take = flags.sq_gt;
			C_BIT_MORE: take = flags.bit_more;
			C_REM_ZERO: take = flags.rem_zero;
			C_NOT_FULL: take = flags.not_full;
			C_NO_IN:    take = !flags.in_req;
			C_OUT_BUSY: take = flags.out_busy;
			default:    take = 1'b0;
		endcase
	end

	// reset enters the table fill at the first step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_DINIT;
		end else begin
			upc_q <= take ? uop.jmp : uop.nxt;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/prs_dpath.sv]
`default_nettype none

module prs_dpath #(
	parameter int PRIME_COUNT = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  prs_pkg::uop_t              uop,
	output prs_pkg::flags_t            flags,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [prs_pkg::IDX_W-1:0]  first_index,
	input  logic [prs_pkg::IDX_W-1:0]  last_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [prs_pkg::SUM_W-1:0]  range_sum,
	output logic                       range_error
);
	import prs_pkg::*;

	localparam int AW = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
	localparam int CW = $clog2(PRIME_COUNT + 1);
	localparam logic [IDX_W-1:0] PCNT = IDX_W'(PRIME_COUNT);
	localparam logic [CW-1:0]    FULL = CW'(PRIME_COUNT);

	// fill state
	logic [CAND_W-1:0]  cand_q;
	logic [CW-1:0]      found_q;
	logic [SUM_W-1:0]   total_q;
	logic [DIV_W-1:0]   d_q;
	logic [REM_W-1:0]   rem_q;
	logic [BIT_W-1:0]   bit_q;

	// query state
	logic [IDX_W-1:0]   first_q;
	logic [IDX_W-1:0]   last_q;
	logic               err_q;
	logic [SUM_W-1:0]   hi_q;
	logic [SUM_W-1:0]   rd_q;
	logic               out_valid_q;
	logic [SUM_W-1:0]   sum_q;
	logic               out_err_q;

	logic [SUM_W-1:0]   mem [PRIME_COUNT];

	logic [2*DIV_W-1:0] sq;
	logic [REM_W:0]     trial;
	logic               fits;
	logic [SUM_W-1:0]   total_nx;
	logic [IDX_W-1:0]   hi_idx;
	logic [IDX_W-1:0]   lo_idx;
	logic [AW-1:0]      rd_addr;
	logic               swapped;
	logic [SUM_W-1:0]   lo_val;
	logic               in_err;
	logic               out_busy;
	logic               load;

	function automatic logic [IDX_W-1:0] clamp(input logic [IDX_W-1:0] v);
		logic [IDX_W-1:0] r;
		r = v;
		if (v == '0)
			r = IDX_W'(1);
		else if (v > PCNT)
			r = PCNT;
		return r;
	endfunction

	assign sq       = d_q * d_q;
	assign trial    = {rem_q, cand_q[bit_q]};
	assign fits     = trial >= {1'b0, d_q};
	assign total_nx = total_q + SUM_W'(cand_q);

	assign in_err = (first_index == '0) || (first_index > PCNT) ||
	                (last_index == '0) || (last_index > PCNT);

	assign hi_idx = last_q - IDX_W'(1);
	assign lo_idx = first_q - IDX_W'(2);
	assign rd_addr = (uop.rd_sel == RD_HI) ? hi_idx[AW-1:0] : lo_idx[AW-1:0];

	assign swapped  = first_q > last_q;
	assign lo_val   = (first_q > IDX_W'(1)) ? rd_q : '0;
	assign out_busy = out_valid_q && out_stall;
	assign load     = uop.result && !out_busy;

	assign flags.lt2      = cand_q < CAND_START;
	assign flags.sq_gt    = sq > (2*DIV_W)'(cand_q);
	assign flags.bit_more = bit_q != '0;
	assign flags.rem_zero = rem_q == '0;
	assign flags.not_full = found_q != FULL;
	assign flags.in_req   = in_valid;
	assign flags.out_busy = out_busy;

	assign in_stall    = !uop.accept;
	assign out_valid   = out_valid_q;
	assign range_sum   = sum_q;
	assign range_error = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q      <= CAND_START;
			found_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (uop.cand_inc)
				cand_q <= cand_q + CAND_W'(1);
			if (uop.prime_wr) begin
				found_q <= found_q + CW'(1);
				total_q <= total_nx;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// trial divisor and bit-serial remainder
	always_ff @(posedge clk) begin
		if (uop.d_init)
			d_q <= DIV_W'(2);
		else if (uop.d_inc)
			d_q <= d_q + DIV_W'(1);
		if (uop.div_init) begin
			rem_q <= '0;
			bit_q <= BIT_TOP;
		end else if (uop.div_step) begin
			rem_q <= fits ? REM_W'(trial - {1'b0, d_q}) : REM_W'(trial);
			bit_q <= bit_q - BIT_W'(1);
		end
	end

	// request capture, prefix reads, result register
	always_ff @(posedge clk) begin
		if (uop.accept && in_valid) begin
			first_q <= clamp(first_index);
			last_q  <= clamp(last_index);
			err_q   <= in_err;
		end
		if (uop.hi_load)
			hi_q <= rd_q;
		if (load) begin
			sum_q     <= swapped ? '0 : hi_q - lo_val;
			out_err_q <= err_q || swapped;
		end
	end

	// prefix table
	always_ff @(posedge clk) begin
		if (uop.prime_wr)
			mem[found_q[AW-1:0]] <= total_nx;
		if (uop.rd_sel != RD_NONE)
			rd_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[hw/rtl/prime_range_sum_unit.sv]
`default_nettype none

// Channel  Handshake            Payload                          Dir
// -------  -------------------  -------------------------------  ---
// request  in_valid / in_stall  first_index[8:0] last_index[8:0]  in
// result   out_valid/out_stall  range_sum[17:0] range_error       out
//
// After reset the sequencer fills the prefix table by trial division;
// in_stall stays high for the whole fill, in which the remainder loop works
// one bit per cycle. Afterwards a request goes through accept, two table
// reads and subtract. A stalled result sits in the output register; the next
// request is taken meanwhile and its result waits in the subtract step until
// the register frees.

module prime_range_sum_unit #(
	parameter int PRIME_COUNT = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [prs_pkg::IDX_W-1:0]  first_index,
	input  logic [prs_pkg::IDX_W-1:0]  last_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [prs_pkg::SUM_W-1:0]  range_sum,
	output logic                       range_error
);
	import prs_pkg::*;

	// control word from the microcode store, status back from the datapath
	uop_t   uop;
	flags_t flags;

	prs_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uop    (uop)
	);

	// datapath: divisor/remainder unit, prefix table, request and result regs
	prs_dpath #(
		.PRIME_COUNT (PRIME_COUNT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.uop         (uop),
		.flags       (flags),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.first_index (first_index),
		.last_index  (last_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.range_sum   (range_sum),
		.range_error (range_error)
	);

endmodule

`default_nettype wire

[hw/rtl/prs_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module prs_prop_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [prs_pkg::IDX_W-1:0]  first_index,
	input logic [prs_pkg::IDX_W-1:0]  last_index,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [prs_pkg::SUM_W-1:0]  range_sum,
	input logic                       range_error
);
	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] pend_q;   // requests taken, results not yet delivered

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
		end
	end

	`ASSERT_NXT(a_req_hold, clk, arst_n, in_valid && in_stall,
		in_valid && $stable(first_index) && $stable(last_index),
		"stalled request changed")
	`ASSERT_NXT(a_res_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(range_sum) && $stable(range_error),
		"stalled result changed")
	`ASSERT_NXT(a_one_at_once, clk, arst_n, in_xfer, in_stall,
		"request taken in back-to-back cycles")
	`ASSERT_IMP(a_no_phantom, clk, arst_n, out_valid, pend_q != 2'd0,
		"result without a pending request")

endmodule

bind prime_range_sum_unit prs_prop_checker u_prs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.first_index (first_index),
	.last_index  (last_index),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.range_sum   (range_sum),
	.range_error (range_error)
);

`default_nettype wire
